>>> rtl/core/ppe_pkg.sv
// shared constants, codes and helpers of the palette pixel expander
package ppe_pkg;

  localparam int unsigned MaxRowPixels   = 4096;
  localparam int unsigned PaletteEntries = 256;

  localparam int unsigned WidthW = 13;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned ColorW = 24;
  localparam int unsigned CountW = 4;
  localparam int unsigned SubW   = 3;

  typedef enum logic [ModeW-1:0] {
    DEPTH_1 = 2'd0,
    DEPTH_4 = 2'd1,
    DEPTH_8 = 2'd2
  } depth_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } op_e;

  typedef enum logic {
    CFG_DEPTH = 1'b0,
    CFG_WIDTH = 1'b1
  } cfg_idx_e;

  // row width clamped to the supported range
  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] w);
    logic [WidthW-1:0] r;
    r = w;
    if (w == '0) begin
      r = WidthW'(1);
    end else if (w > WidthW'(MaxRowPixels)) begin
      r = WidthW'(MaxRowPixels);
    end
    return r;
  endfunction

  // row stride in bytes, rounded up to whole 32-bit words
  function automatic logic [WidthW-1:0] row_stride(input logic [WidthW-1:0] w,
                                                    input logic [ModeW-1:0] mode);
    logic [15:0] wbits;
    logic [16:0] sum;
    wbits = {3'b000, w};
    unique case (mode)
      DEPTH_4: wbits = {1'b0, w, 2'b00};
      DEPTH_8: wbits = {w, 3'b000};
      default: wbits = {3'b000, w};
    endcase
    sum = {1'b0, wbits} + 17'd31;
    return {sum[15:5], 2'b00};
  endfunction

endpackage

>>> rtl/core/palette_pixel_expander.sv
// palette pixel expander top level: row tracking, palette memory and output stage
//
// Each request carries either a palette load or one packed source byte.
// Loads are taken one per cycle, 8-bit bytes too unless the output stalls; a
// 4-bit or 1-bit byte holds the issue stage until all its pixels are read, as
// the palette memory has one read port and gives one pixel per cycle unless
// stalled. Bytes with no pixel (padding, unused depth) leave without a read; a
// pixel goes from the palette read register to the output register. Entries
// read as zero after reset until loaded; there is no clearing pass.
module palette_pixel_expander
  import ppe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [WidthW-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // entry_index, entry_red, entry_green, entry_blue, packed_byte
  input  logic [39:0]          s_axis_tdata_i,
  // operation
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // pixel_blue, pixel_green, pixel_red
  output logic [ColorW-1:0]    m_axis_tdata_o,
  // last_of_byte
  output logic                 m_axis_tuser_o,
  // row_end
  output logic                 m_axis_tlast_o
);

  logic [ModeW-1:0]  depth_q;
  logic [WidthW-1:0] row_width_q;
  logic [WidthW-1:0] col_q, col_d;
  logic [WidthW-1:0] cnt_q, cnt_d;

  logic              a_valid_q, a_valid_d;
  logic              a_load_q;
  logic [IdxW-1:0]   a_idx_q;
  logic [ColorW-1:0] a_rgb_q;
  logic [IdxW-1:0]   a_byte_q;
  logic [ModeW-1:0]  a_mode_q;
  logic [CountW-1:0] a_n_q;
  logic [SubW-1:0]   a_k_q, a_k_d;
  logic              a_re_q;

  logic              b_valid_q, b_valid_d;
  logic              b_last_q;
  logic              b_re_q;
  logic              b_hit_q;

  logic              c_valid_q, c_valid_d;
  logic [ColorW-1:0] c_data_q;
  logic              c_last_q;
  logic              c_re_q;

  logic [ColorW-1:0] pal_mem [PaletteEntries];
  logic [ColorW-1:0] rd_q;
  logic [PaletteEntries-1:0] pal_vld_q;

  logic              accept, in_ready, in_load, mode_ok;
  logic [WidthW-1:0] width, stride, room;
  logic [CountW-1:0] per_byte, n_new;
  logic [WidthW:0]   cnt_inc;
  logic              row_done, re_new;

  logic [IdxW-1:0]   pix_idx;
  logic              a_last, b_free, c_free, b_move;
  logic              pal_we, pal_re, a_done;

  // row position at accept

  assign width  = eff_width(row_width_q);
  assign stride = row_stride(width, depth_q);
  assign room   = width - col_q;

  always_comb begin
    mode_ok  = 1'b1;
    per_byte = 4'd1;
    unique case (depth_q)
      DEPTH_1: per_byte = 4'd8;
      DEPTH_4: per_byte = 4'd2;
      DEPTH_8: per_byte = 4'd1;
      default: mode_ok = 1'b0;
    endcase
  end

  always_comb begin
    n_new = '0;
    if (mode_ok && (col_q < width)) begin
      n_new = (room < WidthW'(per_byte)) ? room[CountW-1:0] : per_byte;
    end
  end

  assign re_new   = (n_new != '0) && ((col_q + WidthW'(n_new)) == width);
  assign cnt_inc  = {1'b0, cnt_q} + (WidthW+1)'(1);
  assign row_done = cnt_inc >= {1'b0, stride};

  assign in_load  = (s_axis_tuser_i == OP_LOAD);
  assign accept   = s_axis_tvalid_i && in_ready;

  always_comb begin
    col_d = col_q;
    cnt_d = cnt_q;
    if (accept && !in_load && mode_ok) begin
      if (row_done) begin
        col_d = '0;
        cnt_d = '0;
      end else begin
        col_d = col_q + WidthW'(n_new);
        cnt_d = cnt_inc[WidthW-1:0];
      end
    end
  end

  // issue stage: one palette access per cycle, reads held while the pixel stages are full

  always_comb begin
    unique case (a_mode_q)
      DEPTH_1: pix_idx = {7'b0, a_byte_q[3'd7 - a_k_q]};
      DEPTH_4: pix_idx = (a_k_q == '0) ? {4'b0, a_byte_q[7:4]} : {4'b0, a_byte_q[3:0]};
      default: pix_idx = a_byte_q;
    endcase
  end

  assign a_last   = ({1'b0, a_k_q} == (a_n_q - 4'd1));
  assign c_free   = !c_valid_q || m_axis_tready_i;
  assign b_free   = !b_valid_q || c_free;
  assign b_move   = b_valid_q && c_free;
  assign pal_we   = a_valid_q && a_load_q;
  assign pal_re   = a_valid_q && !a_load_q && (a_n_q != '0) && b_free;
  assign a_done   = a_valid_q && (a_load_q || (a_n_q == '0) || (pal_re && a_last));
  assign in_ready = !a_valid_q || a_done;

  always_comb begin
    a_valid_d = a_valid_q;
    a_k_d     = a_k_q;
    if (accept) begin
      a_valid_d = 1'b1;
      a_k_d     = '0;
    end else if (a_done) begin
      a_valid_d = 1'b0;
    end else if (pal_re) begin
      a_k_d = a_k_q + SubW'(1);
    end
  end

  always_comb begin
    b_valid_d = b_valid_q && !c_free;
    if (pal_re) begin
      b_valid_d = 1'b1;
    end
    c_valid_d = c_valid_q && !m_axis_tready_i;
    if (b_move) begin
      c_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= DEPTH_8;
      row_width_q <= WidthW'(1);
      col_q       <= '0;
      cnt_q       <= '0;
      a_valid_q   <= 1'b0;
      a_k_q       <= '0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      pal_vld_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DEPTH: depth_q     <= cfg_wdata_i[ModeW-1:0];
          CFG_WIDTH: row_width_q <= cfg_wdata_i;
          default:   depth_q     <= depth_q;
        endcase
      end
      col_q     <= col_d;
      cnt_q     <= cnt_d;
      a_valid_q <= a_valid_d;
      a_k_q     <= a_k_d;
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
      if (pal_we) begin
        pal_vld_q[a_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_load_q <= in_load;
      a_idx_q  <= s_axis_tdata_i[7:0];
      a_rgb_q  <= {s_axis_tdata_i[15:8], s_axis_tdata_i[23:16], s_axis_tdata_i[31:24]};
      a_byte_q <= s_axis_tdata_i[39:32];
      a_mode_q <= depth_q;
      a_n_q    <= in_load ? '0 : n_new;
      a_re_q   <= re_new;
    end
    if (pal_re) begin
      b_last_q <= a_last;
      b_re_q   <= a_last && a_re_q;
      b_hit_q  <= pal_vld_q[pix_idx];
    end
    if (b_move) begin
      c_data_q <= b_hit_q ? rd_q : '0;
      c_last_q <= b_last_q;
      c_re_q   <= b_re_q;
    end
  end

  // palette memory, red in the top byte

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[a_idx_q] <= a_rgb_q;
    end
    if (pal_re) begin
      rd_q <= pal_mem[pix_idx];
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = c_valid_q;
  assign m_axis_tdata_o  = c_data_q;
  assign m_axis_tuser_o  = c_last_q;
  assign m_axis_tlast_o  = c_re_q;

  a_row_end_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("row end on a pixel that is not the last of its byte");

  a_single_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pal_we && pal_re))
    else $error("palette read and write in the same cycle");

  a_sub_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_load_q && (a_n_q != '0) |-> ({1'b0, a_k_q} < a_n_q))
    else $error("sub-pixel index past pixel count");

  a_read_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_re |=> b_valid_q)
    else $error("palette read without a pending pixel");

endmodule

>>> tb/sv/palette_pixel_expander_test.sv
// self-checking testbench of the palette pixel expander with its own pixel predictor
module palette_pixel_expander_test;
  import ppe_pkg::*;

  localparam logic [ModeW-1:0] DepthUnused = 2'd3;
  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 400;
  localparam int StallLimit   = 4000;
  localparam int RandomItems  = 260;

  typedef struct {
    op_e         op;
    logic [39:0] data;
  } request_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last_of_byte;
    logic       row_end;
  } pixel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = 1'b0;
  logic [WidthW-1:0]   cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [39:0]         s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [ColorW-1:0]   m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;

  // predictor state
  logic [ColorW-1:0]   colour_table [PaletteEntries] = '{default: '0};
  logic [ModeW-1:0]    model_mode = DEPTH_8;
  logic [WidthW-1:0]   model_width = 13'd1;
  int                  model_column = 0;
  int                  model_bytes = 0;

  request_t            pending_q [$];
  pixel_t              pixel_q [$];
  request_t            current_req;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  int mismatches = 0;
  int pixels_checked = 0;
  int loads_seen = 0;
  int bytes_seen = 0;
  int settings_written = 0;

  palette_pixel_expander DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_width(logic [WidthW-1:0] width);
    int w;
    w = width;
    if (w == 0) begin
      w = 1;
    end else if (w > MaxRowPixels) begin
      w = MaxRowPixels;
    end
    return w;
  endfunction

  function automatic int stride_bytes(logic [ModeW-1:0] mode, logic [WidthW-1:0] width);
    int bits;
    bits = (mode == DEPTH_1) ? 1 : (mode == DEPTH_4) ? 4 : 8;
    return ((clamp_width(width) * bits + 31) / 32) * 4;
  endfunction

  function automatic void predict_request(request_t req);
    int bits;
    int width;
    int n;
    int k;
    logic [7:0] pbyte;
    logic [7:0] idx;
    pixel_t px;
    if (req.op == OP_LOAD) begin
      colour_table[req.data[7:0]] = {req.data[15:8], req.data[23:16], req.data[31:24]};
      loads_seen++;
      return;
    end
    case (model_mode)
      DEPTH_1: bits = 1;
      DEPTH_4: bits = 4;
      DEPTH_8: bits = 8;
      default: bits = 0;
    endcase
    if (bits == 0) begin
      return;
    end
    bytes_seen++;
    width = clamp_width(model_width);
    pbyte = req.data[39:32];
    n = 0;
    if (model_column < width) begin
      n = width - model_column;
      if (n > 8 / bits) begin
        n = 8 / bits;
      end
    end
    for (k = 0; k < n; k++) begin
      case (bits)
        1: idx = {7'd0, pbyte[7 - k]};
        4: idx = (k == 0) ? {4'd0, pbyte[7:4]} : {4'd0, pbyte[3:0]};
        default: idx = pbyte;
      endcase
      {px.red, px.green, px.blue} = colour_table[idx];
      px.last_of_byte = (k == n - 1);
      px.row_end = (model_column + 1 == width);
      pixel_q.push_back(px);
      model_column++;
    end
    model_bytes++;
    if (model_bytes >= stride_bytes(model_mode, model_width)) begin
      model_bytes = 0;
      model_column = 0;
    end
  endfunction

  function automatic void record_error(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_request(current_req);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          current_req = pending_q.pop_front();
          s_axis_tdata_i <= current_req.data;
          s_axis_tuser_i <= current_req.op;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // pixel monitor and receiver
  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t exp_px;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.blue = m_axis_tdata_o[7:0];
        got.green = m_axis_tdata_o[15:8];
        got.red = m_axis_tdata_o[23:16];
        got.last_of_byte = m_axis_tuser_o;
        got.row_end = m_axis_tlast_o;
        if (pixel_q.size() == 0) begin
          record_error($sformatf("unexpected pixel b %02h g %02h r %02h last %b end %b",
                                 got.blue, got.green, got.red, got.last_of_byte,
                                 got.row_end));
        end else begin
          exp_px = pixel_q.pop_front();
          if (got.blue !== exp_px.blue || got.green !== exp_px.green ||
              got.red !== exp_px.red || got.last_of_byte !== exp_px.last_of_byte ||
              got.row_end !== exp_px.row_end) begin
            record_error($sformatf(
              "pixel %0d: expected b %02h g %02h r %02h last %b end %b, got b %02h g %02h r %02h last %b end %b",
              pixels_checked, exp_px.blue, exp_px.green, exp_px.red,
              exp_px.last_of_byte, exp_px.row_end, got.blue, got.green, got.red,
              got.last_of_byte, got.row_end));
          end
        end
        pixels_checked++;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (long_hold && !hold_done) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void queue_request(op_e op, logic [39:0] data);
    request_t req;
    req.op = op;
    req.data = data;
    pending_q.push_back(req);
  endfunction

  function automatic logic [39:0] random_data();
    return {8'($urandom), 32'($urandom)};
  endfunction

  task automatic settle();
    while (pending_q.size() != 0 || s_axis_tvalid_i || pixel_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reconfigure(logic [ModeW-1:0] mode, logic [WidthW-1:0] width);
    settle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_DEPTH;
    cfg_wdata_i <= {11'($urandom), mode};
    @(posedge clk_i);
    cfg_index_i <= CFG_WIDTH;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_mode = mode;
    model_width = width;
    settings_written++;
  endtask

  initial begin
    int counted;
    int span;
    int pick;
    int i;
    logic [ModeW-1:0] mode;
    logic [WidthW-1:0] width;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 33;
    recv_idle_pct = 81;

    // reset settings, unloaded palette reads as black
    queue_request(OP_DATA, {8'h00, 32'h0});
    queue_request(OP_DATA, {8'hFF, 32'h0});
    queue_request(OP_DATA, {8'h3C, 32'h0});
    queue_request(OP_DATA, {8'hC3, 32'h0});
    queue_request(OP_LOAD, {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    queue_request(OP_LOAD, {8'h00, 8'h7F, 8'h80, 8'h01, 8'hFF});
    queue_request(OP_LOAD, {8'h00, 8'h56, 8'h34, 8'h12, 8'h01});
    queue_request(OP_LOAD, {8'h00, 8'h0F, 8'h55, 8'hAA, 8'h0F});
    queue_request(OP_DATA, {8'hFF, 32'h0});
    queue_request(OP_DATA, {8'h00, 32'h0});
    queue_request(OP_DATA, {8'h00, 32'h0});
    queue_request(OP_DATA, {8'h00, 32'h0});
    // odd width at four bits ends on a high nibble
    reconfigure(DEPTH_4, 13'd3);
    queue_request(OP_DATA, {8'h0F, 32'h0});
    queue_request(OP_DATA, {8'hF1, 32'h0});
    queue_request(OP_DATA, {8'h00, 32'h0});
    queue_request(OP_DATA, {8'h00, 32'h0});
    reconfigure(DEPTH_1, 13'd9);
    queue_request(OP_DATA, {8'hA5, 32'h0});
    queue_request(OP_DATA, {8'h80, 32'h0});
    // row change of width while partway through
    reconfigure(DEPTH_1, 13'd5);
    queue_request(OP_DATA, {8'hFF, 32'h0});
    queue_request(OP_DATA, {8'h00, 32'h0});
    reconfigure(DepthUnused, 13'd9);
    queue_request(OP_DATA, {8'h5A, 32'h0});
    queue_request(OP_LOAD, {8'h00, 8'hC0, 8'h0C, 8'h3A, 8'h80});
    // zero width behaves as one pixel
    reconfigure(DEPTH_8, 13'd0);
    queue_request(OP_DATA, {8'h80, 32'h0});
    queue_request(OP_DATA, {8'h01, 32'h0});

    // output held off so the block backs up
    reconfigure(DEPTH_1, 13'd64);
    long_hold = 1'b1;
    for (i = 0; i < 24; i++) begin
      queue_request(OP_DATA, random_data());
    end

    counted = 0;
    while (counted < RandomItems) begin
      if (counted >= 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (counted >= RandomItems / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 33;
      end
      mode = ($urandom_range(99) < 8) ? DepthUnused : ModeW'($urandom_range(2));
      pick = $urandom_range(99);
      if (pick < 70) begin
        width = WidthW'($urandom_range(24, 1));
      end else if (pick < 80) begin
        width = WidthW'($urandom_range(200, 25));
      end else if (pick < 84) begin
        width = 13'd0;
      end else if (pick < 88) begin
        width = 13'd4096;
      end else if (pick < 92) begin
        width = 13'd8191;
      end else if (pick < 96) begin
        width = 13'd4097;
      end else begin
        width = 13'd4095;
      end
      reconfigure(mode, width);
      if (mode == DepthUnused) begin
        span = 6;
      end else begin
        span = $urandom_range(3, 1) * stride_bytes(mode, width) + $urandom_range(2);
        if (span > 48) begin
          span = 48;
        end
      end
      for (i = 0; i < span; i++) begin
        if ($urandom_range(99) < 15) begin
          queue_request(OP_LOAD, random_data());
          counted++;
        end
        queue_request(OP_DATA, random_data());
        if (mode != DepthUnused) begin
          counted++;
        end
      end
    end
    settle();

    $display("covered %0d palette loads and %0d data bytes over %0d register settings",
             loads_seen, bytes_seen, settings_written);
    $display("%0d pixels compared, %0d mismatches", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
